// ===== src/tdml_pkg.sv =====
// ----------------------------------------------------------------------------
// tdml_pkg
// Shared types and constants for the tanh drive / mix / low-pass block.
// ----------------------------------------------------------------------------
package tdml_pkg;

   localparam int CHANNELS = 2;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Q23 constants of the shaper
   localparam logic [24:0] Q23_ONE    = 25'd8388608;
   localparam logic [28:0] CLIP_LEVEL = 29'd25165824;   // 3.0
   localparam logic [27:0] TANH_K27   = 28'd226492416;  // 27.0

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DRIVE_GAIN = 3'd0,
      CSR_DRY_GAIN   = 3'd1,
      CSR_WET_GAIN   = 3'd2,
      CSR_COEF_B0    = 3'd3,
      CSR_COEF_B1    = 3'd4,
      CSR_COEF_B2    = 3'd5,
      CSR_COEF_A1    = 3'd6,
      CSR_COEF_A2    = 3'd7
   } tdml_csr_type;

   typedef struct packed {
      logic        [15:0] drive_gain;
      logic        [16:0] dry_gain;
      logic        [16:0] wet_gain;
      logic signed [31:0] coef_b0;
      logic signed [31:0] coef_b1;
      logic signed [31:0] coef_b2;
      logic signed [31:0] coef_a1;
      logic signed [31:0] coef_a2;
   } tdml_cfg_type;

   // one classified sample waiting for the back end
   typedef struct packed {
      logic [CH_W-1:0]    ch;
      logic signed [23:0] sample;
      logic               neg;
      logic               clip;
      logic [24:0]        mag;
   } tdml_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tdml_qstat_type;

endpackage

// ===== src/tanh_drive_mix_lowpass.sv =====
// ----------------------------------------------------------------------------
// tanh_drive_mix_lowpass
// Soft-clip drive with dry/wet mix and a per-channel biquad low-pass.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample and its channel; rsp_* returns one filtered
//   sample per request, in request order. A transfer happens on a clock edge
//   with valid high and stall low. Gains and biquad coefficients are written
//   through csr_wr_en / csr_addr / csr_wr_data while no sample is in flight.
// Timing:
//   The front end drives and classifies a sample in the transfer cycle and
//   queues it (two entries). The back end runs a sample whose shaper does
//   not saturate through the one-bit-per-cycle divider of the tanh
//   approximation, and a saturated one straight on to the mix; the result is
//   visible on rsp_* the cycle after. The back end takes the next sample only
//   once the last is done, so the divider and the single multiplier set its rate.
// Reset:
//   Synchronous reset restores the default gains and coefficients and clears
//   the filter state of every channel and the queue.
// Stall:
//   A stalled result stays in the output register; the back end then waits
//   with the next result finished, and req_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module tanh_drive_mix_lowpass
   import tdml_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_channel,
   input  logic signed [23:0]    req_sample_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [23:0]    rsp_sample_out,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   tdml_cfg_type   cfg_ff, cfg_in;
   tdml_item_type  push_item;
   tdml_item_type  head_item;
   tdml_qstat_type qstat;
   logic           push;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_DRIVE_GAIN: cfg_in.drive_gain = csr_wr_data[15:0];
            CSR_DRY_GAIN:   cfg_in.dry_gain   = csr_wr_data[16:0];
            CSR_WET_GAIN:   cfg_in.wet_gain   = csr_wr_data[16:0];
            CSR_COEF_B0:    cfg_in.coef_b0    = csr_wr_data;
            CSR_COEF_B1:    cfg_in.coef_b1    = csr_wr_data;
            CSR_COEF_B2:    cfg_in.coef_b2    = csr_wr_data;
            CSR_COEF_A1:    cfg_in.coef_a1    = csr_wr_data;
            CSR_COEF_A2:    cfg_in.coef_a2    = csr_wr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_gain <= 16'd8192;
         cfg_ff.dry_gain   <= 17'd3480;
         cfg_ff.wet_gain   <= 17'd8125;
         cfg_ff.coef_b0    <= 32'sd268435456;
         cfg_ff.coef_b1    <= '0;
         cfg_ff.coef_b2    <= '0;
         cfg_ff.coef_a1    <= '0;
         cfg_ff.coef_a2    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdml_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_channel   (req_channel),
      .req_sample_in (req_sample_in),
      .drive_gain    (cfg_ff.drive_gain),
      .qstat         (qstat),
      .push          (push),
      .item          (push_item)
   );

   tdml_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   tdml_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_item      (head_item),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ===== src/tdml_front.sv =====
// ----------------------------------------------------------------------------
// tdml_front
// Request side: takes a sample, applies drive and classifies the shaper case.
// ----------------------------------------------------------------------------
module tdml_front
   import tdml_pkg::*;
(
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_channel,
   input  logic signed [23:0] req_sample_in,
   input  logic [15:0]        drive_gain,
   input  tdml_qstat_type     qstat,
   output logic               push,
   output tdml_item_type      item
);

   logic signed [40:0] smp_ext;
   logic signed [40:0] drv_ext;
   logic signed [40:0] prod;
   logic        [40:0] prod_abs;
   logic        [28:0] mag_full;

   always_comb begin
      smp_ext  = 41'(req_sample_in);
      drv_ext  = {25'd0, drive_gain};
      prod     = smp_ext * drv_ext;
      prod_abs = prod[40] ? 41'(-prod) : 41'(prod);
      mag_full = prod_abs[39:11];

      item.ch     = (CHANNELS == 1) ? '0 : CH_W'(req_channel);
      item.sample = req_sample_in;
      item.neg    = prod[40];
      item.clip   = (mag_full >= CLIP_LEVEL);
      item.mag    = mag_full[24:0];
   end

   assign req_stall = qstat.full;
   assign push      = req_valid & ~qstat.full;

endmodule

// ===== src/tdml_queue.sv =====
// ----------------------------------------------------------------------------
// tdml_queue
// Short FIFO between the request front end and the processing back end.
// ----------------------------------------------------------------------------
module tdml_queue
   import tdml_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tdml_item_type  push_item,
   input  logic           pop,
   output tdml_item_type  head_item,
   output tdml_qstat_type qstat
);

   tdml_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
      do_push     = push & ~qstat.full;
      do_pop      = pop & ~qstat.empty;
      head_item   = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/tdml_back.sv =====
// ----------------------------------------------------------------------------
// tdml_back
// Sequencer that runs shaper, mix and biquad on one shared multiplier,
// with a bit-serial divider for the tanh approximation.
// ----------------------------------------------------------------------------
module tdml_back
   import tdml_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tdml_cfg_type       cfg,
   input  tdml_item_type      head_item,
   input  tdml_qstat_type     qstat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_sample_out
);

   localparam int          DIV_STEPS = 27;
   localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_DEN, ST_NUM, ST_DIV_INIT, ST_DIV, ST_TSET,
      ST_DRY, ST_WET, ST_MIX, ST_FB0, ST_FY, ST_FA1, ST_FB2, ST_FA2, ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
      if (v > 41'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -41'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'sd140737488355327) begin
         return {1'b0, {47{1'b1}}};
      end else if (v < -50'sd140737488355328) begin
         return {1'b1, 47'd0};
      end
      return v[47:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
      if (v > 32'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -32'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   state_type          state_ff, state_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic signed [23:0] sample_ff, sample_in;
   logic               neg_ff, neg_in;
   logic [24:0]        mag_ff, mag_in;
   logic [28:0]        sum_ff, sum_in;
   logic [29:0]        den_ff, den_in;
   logic [53:0]        rem_ff, rem_in;
   logic [55:0]        dsh_ff, dsh_in;
   logic [26:0]        quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [24:0] t_ff, t_in;
   logic signed [43:0] acc_ff, acc_in;
   logic signed [27:0] x_ff, x_in;
   logic signed [31:0] f_ff, f_in;
   logic signed [47:0] s1n_ff, s1n_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [47:0] s1_ff [CHANNELS];
   logic signed [47:0] s2_ff [CHANNELS];
   logic               st_wr;
   logic signed [47:0] s2n;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_data_ff, rsp_data_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic               out_free;
   logic [26:0]        sq;
   logic               ge;
   logic [24:0]        tq;
   logic signed [44:0] mix_sum;
   logic signed [48:0] y_sum;
   logic signed [49:0] s1_sum;
   logic signed [49:0] s2_sum;

   assign mul_full = mul_a * mul_b;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sum_in       = sum_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      f_in         = f_ff;
      s1n_in       = s1n_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      pop          = 1'b0;
      st_wr        = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      sq      = prod_ff[49:23];
      ge      = ({2'b00, rem_ff} >= dsh_ff);
      tq      = (quo_ff > 27'(Q23_ONE)) ? Q23_ONE : quo_ff[24:0];
      mix_sum = 45'(acc_ff) + 45'(prod_ff[43:0]);
      y_sum   = 49'(prod_ff >>> 20) + 49'(s1_ff[ch_ff]);
      s1_sum  = 50'(acc_ff) - 50'(prod_ff >>> 20) + 50'(s2_ff[ch_ff]);
      s2_sum  = 50'(acc_ff) - 50'(prod_ff >>> 20);
      s2n     = sat48(s2_sum);

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop       = 1'b1;
               ch_in     = head_item.ch;
               sample_in = head_item.sample;
               neg_in    = head_item.neg;
               mag_in    = head_item.mag;
               if (head_item.clip) begin
                  t_in     = head_item.neg ? -25'(Q23_ONE) : 25'(Q23_ONE);
                  state_in = ST_DRY;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            mul_a    = {8'd0, mag_ff};
            mul_b    = {8'd0, mag_ff};
            prod_in  = mul_full[63:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            sum_in   = 29'(TANH_K27) + 29'(sq);
            den_in   = 30'(TANH_K27) + 30'({sq, 3'b000}) + 30'(sq);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            mul_a    = {8'd0, mag_ff};
            mul_b    = {4'd0, sum_ff};
            prod_in  = mul_full[63:0];
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            rem_in   = prod_ff[53:0];
            dsh_in   = {den_ff, 26'd0};
            quo_in   = '0;
            cnt_in   = DIV_LAST;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (ge) begin
               rem_in = 54'({2'b00, rem_ff} - dsh_ff);
            end
            quo_in = {quo_ff[25:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_TSET;
            end
         end
         ST_TSET: begin
            t_in     = neg_ff ? -25'(tq) : 25'(tq);
            state_in = ST_DRY;
         end
         ST_DRY: begin
            mul_a    = 33'(sample_ff);
            mul_b    = {16'd0, cfg.dry_gain};
            prod_in  = mul_full[63:0];
            state_in = ST_WET;
         end
         ST_WET: begin
            acc_in   = prod_ff[43:0];
            mul_a    = 33'(t_ff);
            mul_b    = {16'd0, cfg.wet_gain};
            prod_in  = mul_full[63:0];
            state_in = ST_MIX;
         end
         ST_MIX: begin
            x_in     = 28'(mix_sum >>> 14);
            state_in = ST_FB0;
         end
         ST_FB0: begin
            mul_a    = 33'(cfg.coef_b0);
            mul_b    = 33'(x_ff);
            prod_in  = mul_full[63:0];
            state_in = ST_FY;
         end
         ST_FY: begin
            f_in     = sat32(41'(y_sum >>> 8));
            mul_a    = 33'(cfg.coef_b1);
            mul_b    = 33'(x_ff);
            prod_in  = mul_full[63:0];
            state_in = ST_FA1;
         end
         ST_FA1: begin
            acc_in   = 44'(prod_ff >>> 20);
            mul_a    = 33'(cfg.coef_a1);
            mul_b    = 33'(f_ff);
            prod_in  = mul_full[63:0];
            state_in = ST_FB2;
         end
         ST_FB2: begin
            s1n_in   = sat48(s1_sum);
            mul_a    = 33'(cfg.coef_b2);
            mul_b    = 33'(x_ff);
            prod_in  = mul_full[63:0];
            state_in = ST_FA2;
         end
         ST_FA2: begin
            acc_in   = 44'(prod_ff >>> 20);
            mul_a    = 33'(cfg.coef_a2);
            mul_b    = 33'(f_ff);
            prod_in  = mul_full[63:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold here until the output register can take the result
            if (out_free) begin
               st_wr        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat24(f_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            s1_ff[i] <= '0;
            s2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_wr) begin
            s1_ff[ch_ff] <= s1n_ff;
            s2_ff[ch_ff] <= s2n;
         end
      end
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      sum_ff      <= sum_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      f_ff        <= f_in;
      s1n_ff      <= s1n_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule
